[rtl/zz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zz_pkg
// Shared types and fixed constants of the zigzag scan reorder block.
// ----------------------------------------------------------------------------
package zz_pkg;

    localparam int unsigned SIZE_W     = 4;   // matrix_size register width
    localparam int unsigned DATA_W     = 32;  // element_value / out_value width
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Top level -> scan sequencer
    typedef struct packed {
        logic start;    // begin a scan of a freshly completed matrix
        logic advance;  // one read address consumed, step to the next
    } seq_ctrl_t;

    // Scan sequencer -> top level
    typedef struct packed {
        logic busy;     // scan addresses still being issued
        logic last;     // current address is the bottom-right corner
    } seq_stat_t;

endpackage

[rtl/zz_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zz_store
// Element store: simple dual-port RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module zz_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned DW    = 32
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/zz_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zz_scan
// Zigzag address sequencer: walks (row, col) over an n x n matrix and
// produces the row-major store address of each step.
// ----------------------------------------------------------------------------
module zz_scan #(
    parameter int unsigned MAX_SIDE = 8,
    parameter int unsigned SW       = 4,
    parameter int unsigned AW       = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  zz_pkg::seq_ctrl_t ctrl,
    input  logic [SW-1:0]     side,
    output zz_pkg::seq_stat_t stat,
    output logic [AW-1:0]     rd_addr
);

    localparam int unsigned RCW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int unsigned PW  = RCW + SW + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic           state_reg, state_next;
    logic [RCW-1:0] row_reg, row_next;
    logic [RCW-1:0] col_reg, col_next;
    logic           up_reg, up_next;
    logic [SW-1:0]  n_reg, n_next;

    logic [SW-1:0]  n_m1;
    logic           row_end, col_end, row_zero, col_zero;
    logic [PW-1:0]  addr_full;

    assign n_m1     = n_reg - SW'(1);
    assign row_end  = (SW'(row_reg) == n_m1);
    assign col_end  = (SW'(col_reg) == n_m1);
    assign row_zero = (row_reg == '0);
    assign col_zero = (col_reg == '0);

    assign addr_full = PW'(row_reg) * PW'(n_reg) + PW'(col_reg);
    assign rd_addr   = addr_full[AW-1:0];

    assign stat.busy = (state_reg == ST_SCAN);
    assign stat.last = row_end && col_end;

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        up_next    = up_reg;
        n_next     = n_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    state_next = ST_SCAN;
                    row_next   = '0;
                    col_next   = '0;
                    up_next    = 1'b1;
                    n_next     = side;
                end
            end
            ST_SCAN: begin
                if (ctrl.advance) begin
                    if (row_end && col_end) begin
                        state_next = ST_IDLE;
                    end else if (up_reg) begin
                        if (col_end) begin
                            row_next = row_reg + RCW'(1);
                            up_next  = 1'b0;
                        end else if (row_zero) begin
                            col_next = col_reg + RCW'(1);
                            up_next  = 1'b0;
                        end else begin
                            row_next = row_reg - RCW'(1);
                            col_next = col_reg + RCW'(1);
                        end
                    end else begin
                        if (row_end) begin
                            col_next = col_reg + RCW'(1);
                            up_next  = 1'b1;
                        end else if (col_zero) begin
                            row_next = row_reg + RCW'(1);
                            up_next  = 1'b1;
                        end else begin
                            row_next = row_reg + RCW'(1);
                            col_next = col_reg - RCW'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        col_reg <= col_next;
        up_reg  <= up_next;
        n_reg   <= n_next;
    end

endmodule

[rtl/zigzag_scan_reorder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_scan_reorder_top
// Collects an n x n matrix in row-major order and streams it out in
// zigzag scan order, tlast on the final element.
// ----------------------------------------------------------------------------
// Elements are loaded in row-major order. When the n*n-th element is taken
// the block stops accepting input while the scan sequencer issues one read
// per cycle on the single read port of the element store; results pass
// through the store's read register and the output register and leave one
// per cycle while m_tready is high. A back-pressured output stalls the read
// sequence. Input is taken again as soon as the last read is issued, so
// loading of the next matrix overlaps the draining of the previous one.
// matrix_size (0 acts as 1, values above MAX_SIDE saturate) must only be
// written while the block is idle; it takes effect on the next element.
module zigzag_scan_reorder_top #(
    parameter int unsigned MAX_SIDE      = 8,
    parameter int unsigned ELEMENT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [zz_pkg::SIZE_W-1:0]   cfg_wr_data,   // matrix_size
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [zz_pkg::DATA_W-1:0]   s_tdata,       // [31:0] element_value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [zz_pkg::DATA_W-1:0]   m_tdata,       // [31:0] out_value
    output logic                        m_tlast        // last_of_scan
);

    localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
    localparam int unsigned LCW   = $clog2(DEPTH + 1);
    localparam int unsigned CW    = 2 * SW + 1;
    localparam int unsigned DW    = zz_pkg::DATA_W;
    localparam int unsigned EW    = ELEMENT_WIDTH;

    logic [zz_pkg::SIZE_W-1:0] size_reg;
    logic [LCW-1:0]            load_cnt_reg, load_cnt_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      rd_last_reg;
    logic                      out_vld_reg, out_vld_next;
    logic [DW-1:0]             out_data_reg;
    logic                      out_last_reg;

    logic [zz_pkg::SIZE_W:0]   size_x;
    logic [SW-1:0]             side;
    logic [2*SW-1:0]           total;
    logic                      in_fire, done;
    logic                      rd_move, issue;
    logic [AW-1:0]             rd_addr;
    logic [EW+DW-1:0]          in_x;
    logic [EW-1:0]             wr_data, rd_data;
    logic [EW+DW-1:0]          rd_x;

    zz_pkg::seq_ctrl_t         ctrl;
    zz_pkg::seq_stat_t         stat;

    // side in use
    assign size_x = {1'b0, size_reg};
    always_comb begin
        if (size_x == '0) begin
            side = SW'(1);
        end else if (size_x > (zz_pkg::SIZE_W + 1)'(MAX_SIDE)) begin
            side = SW'(MAX_SIDE);
        end else begin
            side = SW'(size_x);
        end
    end
    assign total = (2 * SW)'(side) * (2 * SW)'(side);

    assign s_tready = !stat.busy;
    assign in_fire  = s_tvalid && s_tready;
    assign done     = (CW'(load_cnt_reg) + CW'(1)) >= CW'(total);

    assign load_cnt_next = (in_fire && done)  ? '0 :
                           in_fire            ? load_cnt_reg + LCW'(1) :
                                                load_cnt_reg;

    // element keeps its low ELEMENT_WIDTH bits
    assign in_x    = {{EW{1'b0}}, s_tdata};
    assign wr_data = in_x[EW-1:0];

    // read stage -> output register
    assign rd_move = rd_vld_reg && (!out_vld_reg || m_tready);
    assign issue   = stat.busy && (!rd_vld_reg || rd_move);

    assign ctrl.start   = in_fire && done;
    assign ctrl.advance = issue;

    assign rd_vld_next  = issue || (rd_vld_reg && !rd_move);
    assign out_vld_next = rd_move || (out_vld_reg && !m_tready);

    // sign-extend from ELEMENT_WIDTH, keep 32 bits
    assign rd_x = {{DW{rd_data[EW-1]}}, rd_data};

    zz_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (EW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (in_fire),
        .wr_addr (load_cnt_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    zz_scan #(
        .MAX_SIDE (MAX_SIDE),
        .SW       (SW),
        .AW       (AW)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .side    (side),
        .stat    (stat),
        .rd_addr (rd_addr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= zz_pkg::SIZE_RESET;
            load_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            load_cnt_reg <= load_cnt_next;
            rd_vld_reg   <= rd_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_last_reg <= stat.last;
        end
        if (rd_move) begin
            out_data_reg <= rd_x[DW-1:0];
            out_last_reg <= rd_last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
